FILE: hw/rtl/fprd_pkg.sv
// Shared types, constants and the pseudo-random byte table of the frame polarity resolver.
// Used by every RTL module of the block but fprd_checker; depends on nothing else.

package fprd_pkg;

	localparam int FRAME_BYTES_DEF = 1024;
	localparam int SYNC_BYTES      = 4;
	localparam int SEQ_PERIOD      = 255;

	localparam logic [31:0] SYNC_PATTERN_RST = 32'h1DFC_CF1A;

	// APB register map, word index taken from paddr[2].
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_SYNC_PATTERN = 1'b0;

	// Output queue geometry.
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// One queue entry: either a four-byte sync burst or a single data byte.
	typedef struct packed {
		logic [31:0] word;
		logic        burst;
		logic [9:0]  idx;
		logic        inv;
		logic        last;
	} oq_entry_t;

	typedef struct packed {
		logic      push;
		oq_entry_t entry;
	} oq_push_t;

	localparam logic [7:0] PRN_SEQ [SEQ_PERIOD] = '{
		8'hFF, 8'h48, 8'h0E, 8'hC0, 8'h9A, 8'h0D, 8'h70, 8'hBC,
		8'h8E, 8'h2C, 8'h93, 8'hAD, 8'hA7, 8'hB7, 8'h46, 8'hCE,
		8'h5A, 8'h97, 8'h7D, 8'hCC, 8'h32, 8'hA2, 8'hBF, 8'h3E,
		8'h0A, 8'h10, 8'hF1, 8'h88, 8'h94, 8'hCD, 8'hEA, 8'hB1,
		8'hFE, 8'h90, 8'h1D, 8'h81, 8'h34, 8'h1A, 8'hE1, 8'h79,
		8'h1C, 8'h59, 8'h27, 8'h5B, 8'h4F, 8'h6E, 8'h8D, 8'h9C,
		8'hB5, 8'h2E, 8'hFB, 8'h98, 8'h65, 8'h45, 8'h7E, 8'h7C,
		8'h14, 8'h21, 8'hE3, 8'h11, 8'h29, 8'h9B, 8'hD5, 8'h63,
		8'hFD, 8'h20, 8'h3B, 8'h02, 8'h68, 8'h35, 8'hC2, 8'hF2,
		8'h38, 8'hB2, 8'h4E, 8'hB6, 8'h9E, 8'hDD, 8'h1B, 8'h39,
		8'h6A, 8'h5D, 8'hF7, 8'h30, 8'hCA, 8'h8A, 8'hFC, 8'hF8,
		8'h28, 8'h43, 8'hC6, 8'h22, 8'h53, 8'h37, 8'hAA, 8'hC7,
		8'hFA, 8'h40, 8'h76, 8'h04, 8'hD0, 8'h6B, 8'h85, 8'hE4,
		8'h71, 8'h64, 8'h9D, 8'h6D, 8'h3D, 8'hBA, 8'h36, 8'h72,
		8'hD4, 8'hBB, 8'hEE, 8'h61, 8'h95, 8'h15, 8'hF9, 8'hF0,
		8'h50, 8'h87, 8'h8C, 8'h44, 8'hA6, 8'h6F, 8'h55, 8'h8F,
		8'hF4, 8'h80, 8'hEC, 8'h09, 8'hA0, 8'hD7, 8'h0B, 8'hC8,
		8'hE2, 8'hC9, 8'h3A, 8'hDA, 8'h7B, 8'h74, 8'h6C, 8'hE5,
		8'hA9, 8'h77, 8'hDC, 8'hC3, 8'h2A, 8'h2B, 8'hF3, 8'hE0,
		8'hA1, 8'h0F, 8'h18, 8'h89, 8'h4C, 8'hDE, 8'hAB, 8'h1F,
		8'hE9, 8'h01, 8'hD8, 8'h13, 8'h41, 8'hAE, 8'h17, 8'h91,
		8'hC5, 8'h92, 8'h75, 8'hB4, 8'hF6, 8'hE8, 8'hD9, 8'hCB,
		8'h52, 8'hEF, 8'hB9, 8'h86, 8'h54, 8'h57, 8'hE7, 8'hC1,
		8'h42, 8'h1E, 8'h31, 8'h12, 8'h99, 8'hBD, 8'h56, 8'h3F,
		8'hD2, 8'h03, 8'hB0, 8'h26, 8'h83, 8'h5C, 8'h2F, 8'h23,
		8'h8B, 8'h24, 8'hEB, 8'h69, 8'hED, 8'hD1, 8'hB3, 8'h96,
		8'hA5, 8'hDF, 8'h73, 8'h0C, 8'hA8, 8'hAF, 8'hCF, 8'h82,
		8'h84, 8'h3C, 8'h62, 8'h25, 8'h33, 8'h7A, 8'hAC, 8'h7F,
		8'hA4, 8'h07, 8'h60, 8'h4D, 8'h06, 8'hB8, 8'h5E, 8'h47,
		8'h16, 8'h49, 8'hD6, 8'hD3, 8'hDB, 8'hA3, 8'h67, 8'h2D,
		8'h4B, 8'hBE, 8'hE6, 8'h19, 8'h51, 8'h5F, 8'h9F, 8'h05,
		8'h08, 8'h78, 8'hC4, 8'h4A, 8'h66, 8'hF5, 8'h58
	};

endpackage

FILE: hw/rtl/fprd_regs.sv
// APB configuration register holding the expected sync pattern.
// Depends on fprd_pkg for the register map and reset value.

module fprd_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fprd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [fprd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [fprd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output logic [31:0]                    sync_pattern
);

	logic [31:0] sync_pattern_q;
	logic        sel_sync;

	assign sel_sync = (paddr[2] == fprd_pkg::REG_SYNC_PATTERN);
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_pattern_q <= fprd_pkg::SYNC_PATTERN_RST;
		end else if (psel && penable && pwrite && sel_sync) begin
			sync_pattern_q <= pwdata;
		end
	end

	assign prdata       = sel_sync ? sync_pattern_q : '0;
	assign sync_pattern = sync_pattern_q;

endmodule

FILE: hw/rtl/fprd_proc.sv
// Input register and per-byte frame logic: sync collection, polarity decision and derandomizing.
// Depends on fprd_pkg for the queue entry type and the pseudo-random table.

module fprd_proc #(
	parameter int FRAME_BYTES = fprd_pkg::FRAME_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          frame_start,
	input  logic [31:0]                   sync_pattern,
	input  logic [fprd_pkg::OQ_CNT_W-1:0] oq_count,
	output fprd_pkg::oq_push_t            oq_push
);

	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] POS_SYNC_LAST = POS_W'(fprd_pkg::SYNC_BYTES - 1);
	localparam logic [7:0] SEQ_LAST = 8'(fprd_pkg::SEQ_PERIOD - 1);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             start_s1;

	logic [POS_W-1:0] pos_q;
	logic [31:0]      hold_q;
	logic             inv_q;
	logic [7:0]       seq_q;

	logic [POS_W-1:0] pos_cur;
	logic             first;
	logic [31:0]      hold_base;
	logic             inv_base;
	logic [7:0]       seq_base;
	logic             is_sync;
	logic             sync_done;
	logic [31:0]      hold_new;
	logic [5:0]       sync_dist;
	logic             inv_det;
	logic [31:0]      sync_word;
	logic [7:0]       data_out;
	logic             last;

	// Room is checked against what the byte now in the input register will still push.
	assign in_ready = ({1'b0, oq_count} + (fprd_pkg::OQ_CNT_W + 1)'(oq_push.push))
		< (fprd_pkg::OQ_CNT_W + 1)'(fprd_pkg::OQ_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			start_s1 <= frame_start;
		end
	end

	always_comb begin
		pos_cur   = start_s1 ? '0 : pos_q;
		first     = (pos_cur == '0);
		hold_base = first ? '0 : hold_q;
		inv_base  = first ? 1'b0 : inv_q;
		seq_base  = first ? '0 : seq_q;
		is_sync   = (pos_cur <= POS_SYNC_LAST);
		sync_done = (pos_cur == POS_SYNC_LAST);
		for (int k = 0; k < fprd_pkg::SYNC_BYTES; k++) begin
			hold_new[8*k +: 8] = (pos_cur == POS_W'(k)) ? byte_s1 : hold_base[8*k +: 8];
		end
		// The distance to the complement is 32 minus the distance to the pattern,
		// so the complement is strictly closer exactly when more than half the bits differ.
		sync_dist = 6'($countones(hold_new ^ sync_pattern));
		inv_det   = (sync_dist > 6'd16);
		sync_word = inv_det ? ~hold_new : hold_new;
		data_out  = byte_s1 ^ {8{inv_base}} ^ fprd_pkg::PRN_SEQ[seq_base];
		last      = (pos_cur == POS_LAST);

		oq_push.push        = valid_s1 && (!is_sync || sync_done);
		oq_push.entry.word  = is_sync ? sync_word : {24'd0, data_out};
		oq_push.entry.burst = is_sync;
		oq_push.entry.idx   = 10'(pos_cur);
		oq_push.entry.inv   = is_sync ? inv_det : inv_base;
		oq_push.entry.last  = !is_sync && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hold_q <= '0;
			inv_q  <= 1'b0;
			seq_q  <= '0;
		end else if (valid_s1) begin
			pos_q <= last ? '0 : POS_W'(pos_cur + 1'b1);
			if (is_sync) begin
				hold_q <= sync_done ? sync_word : hold_new;
				inv_q  <= sync_done ? inv_det : inv_base;
				seq_q  <= seq_base;
			end else begin
				hold_q <= hold_base;
				inv_q  <= inv_base;
				seq_q  <= (seq_base == SEQ_LAST) ? '0 : 8'(seq_base + 1'b1);
			end
		end
	end

endmodule

FILE: hw/rtl/fprd_outq.sv
// Result queue: holds single data bytes and four-byte sync bursts and unpacks them onto the output.
// Depends on fprd_pkg for the entry type and queue geometry.

module fprd_outq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fprd_pkg::oq_push_t            oq_push,
	output logic [fprd_pkg::OQ_CNT_W-1:0] oq_count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_byte,
	output logic [9:0]                    byte_index,
	output logic                          polarity_inverted,
	output logic                          last_of_frame
);

	fprd_pkg::oq_entry_t              entry_q [fprd_pkg::OQ_DEPTH];
	logic [fprd_pkg::OQ_PTR_W-1:0]    wr_ptr_q;
	logic [fprd_pkg::OQ_PTR_W-1:0]    rd_ptr_q;
	logic [fprd_pkg::OQ_CNT_W-1:0]    count_q;
	logic [1:0]                       lane_q;
	fprd_pkg::oq_entry_t              head;
	logic                             xfer;
	logic                             pop;

	assign head      = entry_q[rd_ptr_q];
	assign out_valid = (count_q != '0);
	assign xfer      = out_valid && out_ready;
	// A burst entry leaves only after its fourth byte has been transferred.
	assign pop       = xfer && (!head.burst || lane_q == 2'd3);

	assign out_byte          = head.burst ? head.word[8*lane_q +: 8] : head.word[7:0];
	assign byte_index        = head.burst ? 10'(lane_q) : head.idx;
	assign polarity_inverted = head.inv;
	assign last_of_frame     = head.last;
	assign oq_count          = count_q;

	always_ff @(posedge clk) begin
		if (oq_push.push) begin
			entry_q[wr_ptr_q] <= oq_push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			lane_q   <= '0;
		end else begin
			if (oq_push.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
				lane_q   <= '0;
			end else if (xfer) begin
				lane_q <= lane_q + 1'b1;
			end
			count_q <= count_q + fprd_pkg::OQ_CNT_W'(oq_push.push)
				- fprd_pkg::OQ_CNT_W'(pop);
		end
	end

endmodule

FILE: hw/rtl/frame_polarity_resolve_derandomizer.sv
// Top level of the frame polarity resolver and derandomizer.
// Instantiates fprd_regs, fprd_proc and fprd_outq; depends on fprd_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------------
//   input    | in_valid / in_ready    | data_byte, frame_start
//   output   | out_valid / out_ready  | out_byte, byte_index, polarity_inverted,
//            |                        | last_of_frame
//   config   | APB psel/penable/pready| paddr, pwdata, prdata (sync_pattern at 0x0)
//
// A byte can be transferred in every cycle while in_ready is high. It is held in the input
// register, where the frame logic runs, and its result then enters a four-entry queue, from
// which it can leave. The fourth sync byte yields one burst entry of four results, sent one per
// cycle while out_ready is high, as the first data bytes of the frame queue behind it; with
// out_ready high this can stall the input. in_ready drops when the queue, counting the entry
// still due from the input register, would be full. Reset clears the frame state and the queue.

module frame_polarity_resolve_derandomizer #(
	parameter int FRAME_BYTES = fprd_pkg::FRAME_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      data_byte,
	input  logic                            frame_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      out_byte,
	output logic [9:0]                      byte_index,
	output logic                            polarity_inverted,
	output logic                            last_of_frame,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fprd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [fprd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [fprd_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	logic [31:0]                   sync_pattern;
	logic [fprd_pkg::OQ_CNT_W-1:0] oq_count;
	fprd_pkg::oq_push_t            oq_push;

	fprd_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sync_pattern (sync_pattern)
	);

	fprd_proc #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_proc (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.frame_start  (frame_start),
		.sync_pattern (sync_pattern),
		.oq_count     (oq_count),
		.oq_push      (oq_push)
	);

	fprd_outq u_outq (
		.clk               (clk),
		.arst_n            (arst_n),
		.oq_push           (oq_push),
		.oq_count          (oq_count),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_byte          (out_byte),
		.byte_index        (byte_index),
		.polarity_inverted (polarity_inverted),
		.last_of_frame     (last_of_frame)
	);

endmodule

FILE: hw/rtl/fprd_checker.sv
// Port-level checks of the frame polarity resolver, bound to its top level.
// Sees only the top-level ports; depends on nothing else.

module fprd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [9:0] byte_index
);

	// A stalled result keeps its byte and position.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_index))
		else $error("stalled result changed");

	// With no result waiting the queue has room, so input must never be blocked.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while no result is pending");

	// A result that appears must follow an input transfer that passed through the input register into the queue.
	a_rose_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a matching input transfer");

endmodule

bind frame_polarity_resolve_derandomizer fprd_checker u_fprd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.byte_index (byte_index)
);

FILE: bench/frame_polarity_resolve_derandomizer_tb.sv
`timescale 1ns / 1ps
// Testbench for frame_polarity_resolve_derandomizer: polarity decision, sync burst and
// derandomized data bytes are predicted per input transfer and checked per output transfer.
// Depends on fprd_pkg and the block's RTL only.

module frame_polarity_resolve_derandomizer_tb;

	localparam int FRAME_LEN = fprd_pkg::FRAME_BYTES_DEF;
	localparam int LIMIT_CYCLES = 500000;
	localparam int SETTLE_CYCLES = 6;
	localparam logic [fprd_pkg::APB_ADDR_W-1:0] SYNC_PATTERN_ADDR =
		{fprd_pkg::REG_SYNC_PATTERN, 2'b00};

	typedef struct {
		logic [7:0] value;
		logic [9:0] idx;
		logic       inv;
		logic       last;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] data_byte;
	logic frame_start;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_byte;
	logic [9:0] byte_index;
	logic polarity_inverted;
	logic last_of_frame;
	logic psel;
	logic penable;
	logic pwrite;
	logic [fprd_pkg::APB_ADDR_W-1:0] paddr;
	logic [fprd_pkg::APB_DATA_W-1:0] pwdata;
	logic [fprd_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	// Predictor state: a private copy of the frame logic and of the sync register.
	logic [31:0] sync_pattern_cfg = fprd_pkg::SYNC_PATTERN_RST;
	logic [31:0] sync_word = '0;
	logic frame_inv = 1'b0;
	int frame_pos = 0;
	int prn_pos = 0;
	logic [7:0] prn_table [fprd_pkg::SEQ_PERIOD];

	frame_byte_t expected_bytes [$];
	int mismatch_count = 0;
	int items_sent = 0;
	int unsigned cycle_count = 0;
	bit in_gaps_on = 1'b0;
	bit out_stalls_on = 1'b0;
	int stall_left = 0;

	frame_polarity_resolve_derandomizer #(
		.FRAME_BYTES(FRAME_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.byte_index(byte_index),
		.polarity_inverted(polarity_inverted),
		.last_of_frame(last_of_frame),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// The sequence comes from x^8 + x^7 + x^5 + x^3 + 1 with an all-ones seed, MSB first.
	initial begin : prn_gen
		bit bits [fprd_pkg::SEQ_PERIOD * 8];
		for (int n = 0; n < 8; n++)
			bits[n] = 1'b1;
		for (int n = 8; n < fprd_pkg::SEQ_PERIOD * 8; n++)
			bits[n] = bits[n - 8] ^ bits[n - 5] ^ bits[n - 3] ^ bits[n - 1];
		for (int i = 0; i < fprd_pkg::SEQ_PERIOD; i++)
			for (int j = 0; j < 8; j++)
				prn_table[i][7 - j] = bits[8 * i + j];
	end

	function automatic int pick_delay(input bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic predict_frame_byte(input logic [7:0] b, input logic st);
		frame_byte_t r;
		logic at_end;
		if (st || frame_pos >= FRAME_LEN)
			frame_pos = 0;
		if (frame_pos == 0) begin
			sync_word = '0;
			frame_inv = 1'b0;
			prn_pos = 0;
		end
		at_end = (frame_pos == FRAME_LEN - 1);
		if (frame_pos < fprd_pkg::SYNC_BYTES) begin
			sync_word |= 32'(b) << (8 * frame_pos);
			if (frame_pos == fprd_pkg::SYNC_BYTES - 1) begin
				// A tie in distance keeps true polarity.
				frame_inv = $countones(sync_word ^ ~sync_pattern_cfg) <
					$countones(sync_word ^ sync_pattern_cfg);
				if (frame_inv)
					sync_word = ~sync_word;
				for (int k = 0; k < fprd_pkg::SYNC_BYTES; k++) begin
					r.value = sync_word[8 * k +: 8];
					r.idx = 10'(k);
					r.inv = frame_inv;
					r.last = 1'b0;
					expected_bytes.push_back(r);
				end
			end
		end else begin
			r.value = b ^ {8{frame_inv}} ^ prn_table[prn_pos];
			r.idx = frame_pos[9:0];
			r.inv = frame_inv;
			r.last = at_end;
			expected_bytes.push_back(r);
			prn_pos = (prn_pos + 1) % fprd_pkg::SEQ_PERIOD;
		end
		frame_pos = at_end ? 0 : frame_pos + 1;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic st);
		int gap;
		gap = pick_delay(in_gaps_on);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		frame_start <= st;
		predict_frame_byte(b, st);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_sync(input logic [31:0] word, input logic st);
		send_byte(word[7:0], st);
		for (int k = 1; k < fprd_pkg::SYNC_BYTES; k++)
			send_byte(word[8 * k +: 8], 1'b0);
	endtask

	// Stops the input side and waits until every predicted byte has left the block.
	task automatic drain_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sync_pattern(input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SYNC_PATTERN_ADDR;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sync_pattern_cfg = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== value) begin
			$display("%0t: sync_pattern read expected %h actual %h", $time, value, prdata);
			mismatch_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// The first frame after reset needs no frame start; data extremes follow the sync.
	task automatic test_reset_frame();
		send_sync(fprd_pkg::SYNC_PATTERN_RST, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b0);
	endtask

	task automatic test_polarity_decisions();
		send_sync(~sync_pattern_cfg, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// Sixteen bits off from each pattern is a tie.
		send_sync(sync_pattern_cfg ^ 32'h0F0F_0F0F, 1'b1);
		send_byte(8'h3C, 1'b0);
		// Seventeen bits off makes the inverted pattern strictly closer.
		send_sync(sync_pattern_cfg ^ 32'h0F0F_0F1F, 1'b1);
	endtask

	task automatic test_restart_mid_frame();
		send_byte(8'h1A, 1'b1);
		send_byte(8'hCF, 1'b0);
		send_sync(sync_pattern_cfg, 1'b1);
		send_byte(8'h81, 1'b0);
		send_byte(8'h7E, 1'b1);
	endtask

	// A frame long enough for the sequence to run past its last entry and start over.
	task automatic test_sequence_wrap();
		in_gaps_on = 1'b1;
		out_stalls_on = 1'b1;
		send_sync(~sync_pattern_cfg, 1'b1);
		repeat (fprd_pkg::SEQ_PERIOD + 3) send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic send_random_frame();
		int kind;
		int n;
		int flips;
		logic [31:0] word;
		kind = $urandom_range(0, 99);
		if (kind < 75) begin
			n = $urandom_range(0, 99);
			flips = (n < 50) ? $urandom_range(0, 3) :
				(n < 85) ? $urandom_range(4, 12) : $urandom_range(13, 19);
			word = $urandom_range(0, 1) ? ~sync_pattern_cfg : sync_pattern_cfg;
			repeat (flips) word[$urandom_range(0, 31)] ^= 1'b1;
			send_sync(word, $urandom_range(0, 9) != 0);
			n = $urandom_range(0, 24);
			repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			n = $urandom_range(1, 8);
			repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
		end
	endtask

	task automatic test_random_phases();
		logic [31:0] settings [6];
		int phase_start;
		settings = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, fprd_pkg::SYNC_PATTERN_RST,
			32'h0000_FFFF, $urandom};
		foreach (settings[p]) begin
			drain_block();
			write_sync_pattern(settings[p]);
			in_gaps_on = $urandom_range(0, 2) != 0;
			out_stalls_on = $urandom_range(0, 2) != 0;
			phase_start = items_sent;
			while (items_sent - phase_start < 24)
				send_random_frame();
		end
	endtask

	always @(negedge clk) begin
		if (stall_left == 0 && $urandom_range(0, 3) == 0)
			stall_left = pick_delay(out_stalls_on);
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_output
		frame_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected output transfer, byte %h index %0d",
					$time, out_byte, byte_index);
				mismatch_count++;
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.value) begin
					$display("%0t: out_byte expected %h actual %h", $time, want.value, out_byte);
					mismatch_count++;
				end
				if (byte_index !== want.idx) begin
					$display("%0t: byte_index expected %0d actual %0d",
						$time, want.idx, byte_index);
					mismatch_count++;
				end
				if (polarity_inverted !== want.inv) begin
					$display("%0t: polarity_inverted expected %b actual %b",
						$time, want.inv, polarity_inverted);
					mismatch_count++;
				end
				if (last_of_frame !== want.last) begin
					$display("%0t: last_of_frame expected %b actual %b",
						$time, want.last, last_of_frame);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		frame_start = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_frame();
		test_polarity_decisions();
		test_restart_mid_frame();
		test_sequence_wrap();
		test_random_phases();
		drain_block();

		if (mismatch_count == 0 && expected_bytes.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
